### rtl/biou_pkg.sv
// ---------------------------------------------------------------------------
// biou_pkg: shared types and constants for the box overlap ratio block
// Fixed field widths and the records that pass between pipeline sections.
// ---------------------------------------------------------------------------
package biou_pkg;

  // box sizes are always 12-bit unsigned
  localparam int SIZE_W = 12;
  // area of one box or of the overlap
  localparam int AREA_W = 2 * SIZE_W;

  // products leaving the geometry section
  typedef struct packed {
    logic [AREA_W-1:0] inter;
    logic [AREA_W-1:0] area_a;
    logic [AREA_W-1:0] area_b;
    logic              overlap;
  } biou_prod_t;

  // operands entering the divider
  typedef struct packed {
    logic [AREA_W-1:0] inter;
    logic [AREA_W:0]   uni;
    logic              force_zero;
    logic              empty;
  } biou_union_t;

endpackage

### rtl/box_in_if.sv
// ---------------------------------------------------------------------------
// box_in_if: channel carrying one pair of boxes
// Valid/ready handshake with both boxes as corner, width and height.
// ---------------------------------------------------------------------------
interface box_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_a_x;
  logic signed [COORD_BITS-1:0] box_a_y;
  logic        [11:0]           box_a_width;
  logic        [11:0]           box_a_height;
  logic signed [COORD_BITS-1:0] box_b_x;
  logic signed [COORD_BITS-1:0] box_b_y;
  logic        [11:0]           box_b_width;
  logic        [11:0]           box_b_height;

  modport source (
    output valid, box_a_x, box_a_y, box_a_width, box_a_height,
           box_b_x, box_b_y, box_b_width, box_b_height,
    input  ready
  );

  modport sink (
    input  valid, box_a_x, box_a_y, box_a_width, box_a_height,
           box_b_x, box_b_y, box_b_width, box_b_height,
    output ready
  );
endinterface

### rtl/box_out_if.sv
// ---------------------------------------------------------------------------
// box_out_if: channel carrying one overlap ratio result
// Valid/ready handshake with the ratio and the empty-union flag.
// ---------------------------------------------------------------------------
interface box_out_if #(
  parameter int FRACTION_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [FRACTION_BITS:0] overlap_ratio;
  logic                   empty_union;

  modport source (
    output valid, overlap_ratio, empty_union,
    input  ready
  );

  modport sink (
    input  valid, overlap_ratio, empty_union,
    output ready
  );
endinterface

### rtl/box_iou_top.sv
// ---------------------------------------------------------------------------
// box_iou_top: intersection over union of two axis-aligned boxes
// Pipelined edges, areas, union and a bit-per-stage divider to a
// fixed-point ratio with FRACTION_BITS fraction bits, truncated.
// ---------------------------------------------------------------------------
//
//   channel   dir   transfer carries
//   -------   ---   -------------------------------------------------
//   boxes     in    box_a/box_b x, y (signed), width, height (12 bit)
//   result    out   overlap_ratio (FRACTION_BITS+1), empty_union
//
// one box pair per cycle sustained while result.ready allows; the pipeline is
// three geometry stages, one union stage, FRACTION_BITS + 1 divider
// stages and one output register; the divider's one quotient bit per
// stage sets the depth
// synchronous active-high rst clears only the valid bits of every stage
// each stage holds under stall and takes new data once it empties or its
// successor moves, so bubbles close up and input keeps flowing while a
// finished result waits on result.ready, until every stage holds a pair
//
module box_iou_top
  import biou_pkg::*;
#(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  box_in_if.sink    boxes,
  box_out_if.source result
);

  // geometry -> union
  logic        g_valid, g_ready;
  biou_prod_t  g_data;
  // union -> divider
  logic        u_valid, u_ready;
  biou_union_t u_data;
  // divider -> output register
  logic                   d_valid, d_ready;
  logic [FRACTION_BITS:0] d_quo;
  logic                   d_fz, d_em;

  logic                   out_valid;
  logic [FRACTION_BITS:0] out_ratio;
  logic                   out_empty;
  logic                   out_en;

  // edges, spans and the three areas
  biou_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk      (clk),
    .rst      (rst),
    .up_valid (boxes.valid),
    .up_ready (boxes.ready),
    .ax       (boxes.box_a_x),
    .ay       (boxes.box_a_y),
    .aw       (boxes.box_a_width),
    .ah       (boxes.box_a_height),
    .bx       (boxes.box_b_x),
    .by       (boxes.box_b_y),
    .bw       (boxes.box_b_width),
    .bh       (boxes.box_b_height),
    .dn_valid (g_valid),
    .dn_ready (g_ready),
    .dn_data  (g_data)
  );

  // union area and the disjoint / empty-union decisions
  biou_union u_union (
    .clk      (clk),
    .rst      (rst),
    .up_valid (g_valid),
    .up_ready (g_ready),
    .up_data  (g_data),
    .dn_valid (u_valid),
    .dn_ready (u_ready),
    .dn_data  (u_data)
  );

  // (overlap << FRACTION_BITS) / union
  biou_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (u_valid),
    .up_ready      (u_ready),
    .up_data       (u_data),
    .dn_valid      (d_valid),
    .dn_ready      (d_ready),
    .dn_quo        (d_quo),
    .dn_force_zero (d_fz),
    .dn_empty      (d_em)
  );

  // output register: disjoint boxes and empty unions give a zero ratio
  assign out_en  = !out_valid || result.ready;
  assign d_ready = out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_ratio <= d_fz ? '0 : d_quo;
      out_empty <= d_em;
    end
  end

  assign result.valid         = out_valid;
  assign result.overlap_ratio = out_ratio;
  assign result.empty_union   = out_empty;

  // an empty union always reports a zero ratio
  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_ratio == '0)
    else $error("empty union with nonzero ratio");

  // the ratio never exceeds one
  a_ratio_max : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ratio[FRACTION_BITS] |-> out_ratio[FRACTION_BITS-1:0] == '0)
    else $error("ratio above one");

  // reset empties the output stage
  a_reset_clear : assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

### rtl/biou_geom.sv
// ---------------------------------------------------------------------------
// biou_geom: overlap edges, spans and areas
// Three register stages: edges, spans with overlap test, then products.
// ---------------------------------------------------------------------------
module biou_geom
  import biou_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic        [SIZE_W-1:0]     aw,
  input  logic        [SIZE_W-1:0]     ah,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic        [SIZE_W-1:0]     bw,
  input  logic        [SIZE_W-1:0]     bh,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output biou_prod_t                   dn_data
);

  // edge width: coordinate plus size plus sign headroom
  localparam int EW = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;

  logic signed [EW-1:0] ax_e, ay_e, bx_e, by_e;
  logic signed [EW-1:0] ar_e, ab_e, br_e, bb_e;
  logic signed [EW-1:0] left_c, top_c, right_c, bottom_c;
  logic signed [EW-1:0] sw_c, sh_c;

  logic                 v1, v2, v3;
  logic                 en1, en2, en3;

  // stage 1 registers
  logic signed [EW-1:0] left, top, right, bottom;
  logic [SIZE_W-1:0]    aw1, ah1, bw1, bh1;
  // stage 2 registers
  logic [SIZE_W-1:0]    sw2, sh2, aw2, ah2, bw2, bh2;
  logic                 ovl2;

  assign en3 = !v3 || dn_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign up_ready = en1;
  assign dn_valid = v3;

  always_comb begin
    ax_e = EW'(ax);
    ay_e = EW'(ay);
    bx_e = EW'(bx);
    by_e = EW'(by);
    ar_e = ax_e + EW'(signed'({1'b0, aw}));
    ab_e = ay_e + EW'(signed'({1'b0, ah}));
    br_e = bx_e + EW'(signed'({1'b0, bw}));
    bb_e = by_e + EW'(signed'({1'b0, bh}));
    left_c   = (ax_e > bx_e) ? ax_e : bx_e;
    top_c    = (ay_e > by_e) ? ay_e : by_e;
    right_c  = (ar_e < br_e) ? ar_e : br_e;
    bottom_c = (ab_e < bb_e) ? ab_e : bb_e;
  end

  // a nonnegative span never exceeds the smaller size, so 12 bits hold it
  assign sw_c = right - left;
  assign sh_c = bottom - top;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      left   <= left_c;
      top    <= top_c;
      right  <= right_c;
      bottom <= bottom_c;
      aw1    <= aw;
      ah1    <= ah;
      bw1    <= bw;
      bh1    <= bh;
    end
    if (en2) begin
      sw2  <= sw_c[SIZE_W-1:0];
      sh2  <= sh_c[SIZE_W-1:0];
      ovl2 <= !sw_c[EW-1] && !sh_c[EW-1];
      aw2  <= aw1;
      ah2  <= ah1;
      bw2  <= bw1;
      bh2  <= bh1;
    end
    if (en3) begin
      dn_data.inter   <= sw2 * sh2;
      dn_data.area_a  <= aw2 * ah2;
      dn_data.area_b  <= bw2 * bh2;
      dn_data.overlap <= ovl2;
    end
  end

endmodule

### rtl/biou_union.sv
// ---------------------------------------------------------------------------
// biou_union: union area and special-case flags
// One register stage forming area_a + area_b - overlap and its zero test.
// ---------------------------------------------------------------------------
module biou_union
  import biou_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  biou_prod_t  up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output biou_union_t dn_data
);

  logic            v;
  logic            en;
  logic [AREA_W:0] uni_c;
  logic            zero_c;

  assign en       = !v || dn_ready;
  assign up_ready = en;
  assign dn_valid = v;

  // overlap never exceeds either area, so the union cannot go negative
  assign uni_c  = {1'b0, up_data.area_a} + {1'b0, up_data.area_b} - {1'b0, up_data.inter};
  assign zero_c = (uni_c == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_data.inter      <= up_data.inter;
      dn_data.uni        <= uni_c;
      dn_data.force_zero <= !up_data.overlap || zero_c;
      dn_data.empty      <= up_data.overlap && zero_c;
    end
  end

endmodule

### rtl/biou_div.sv
// ---------------------------------------------------------------------------
// biou_div: pipelined restoring divider
// One quotient bit per stage, FRACTION_BITS + 1 stages, overlap <= union.
// ---------------------------------------------------------------------------
module biou_div
  import biou_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  biou_union_t            up_data,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [FRACTION_BITS:0] dn_quo,
  output logic                   dn_force_zero,
  output logic                   dn_empty
);

  localparam int NS = FRACTION_BITS + 1;
  // partial remainder stays below twice the divisor
  localparam int RW = AREA_W + 2;

  logic [NS-1:0]        v;
  logic [NS:0]          rdy;
  logic [RW-1:0]        rem [0:NS-1];
  logic [AREA_W:0]      dvs [0:NS-1];
  logic [NS-1:0]        quo [0:NS-1];
  logic [NS-1:0]        fz;
  logic [NS-1:0]        em;

  assign rdy[NS]  = dn_ready;
  assign up_ready = rdy[0];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic            s_v;
    logic [RW-1:0]   s_rem;
    logic [AREA_W:0] s_dvs;
    logic [NS-1:0]   s_quo;
    logic            s_fz;
    logic            s_em;
    logic            ge;
    logic [RW-1:0]   diff;
    logic [RW-1:0]   r;

    if (j == 0) begin : g_first
      assign s_v   = up_valid;
      assign s_rem = RW'(up_data.inter);
      assign s_dvs = up_data.uni;
      assign s_quo = '0;
      assign s_fz  = up_data.force_zero;
      assign s_em  = up_data.empty;
    end else begin : g_next
      assign s_v   = v[j-1];
      assign s_rem = rem[j-1];
      assign s_dvs = dvs[j-1];
      assign s_quo = quo[j-1];
      assign s_fz  = fz[j-1];
      assign s_em  = em[j-1];
    end

    assign rdy[j] = !v[j] || rdy[j+1];
    assign ge     = (s_rem >= RW'(s_dvs));
    assign diff   = s_rem - RW'(s_dvs);
    assign r      = ge ? diff : s_rem;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        rem[j] <= {r[RW-2:0], 1'b0};
        dvs[j] <= s_dvs;
        quo[j] <= {s_quo[NS-2:0], ge};
        fz[j]  <= s_fz;
        em[j]  <= s_em;
      end
    end
  end

  assign dn_valid      = v[NS-1];
  assign dn_quo        = quo[NS-1];
  assign dn_force_zero = fz[NS-1];
  assign dn_empty      = em[NS-1];

endmodule
